FILE: design/bblur_pkg.sv
// bblur_pkg: shared constants, types and helpers of the 5x5 rgb box blur
// used by every module of the block but bblur_ram; no dependencies
`default_nettype none

package bblur_pkg;

  // frame geometry limits
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WREG_W    = 11;
  localparam int HREG_W    = 12;
  localparam int LAG_W     = 12;

  // neighborhood shape
  localparam int RADIUS = 2;
  localparam int DIAM   = 2 * RADIUS + 1;
  localparam int LINES  = 2 * RADIUS;

  // pixel packing: red in the low byte, then green, then blue
  localparam int CHAN_W = 8;
  localparam int NCHAN  = 3;
  localparam int PIX_W  = NCHAN * CHAN_W;
  localparam int LINE_WORD_W = LINES * PIX_W;

  // sums: one column of five samples, then five columns
  localparam int CSUM_W = 11;
  localparam int TSUM_W = 13;

  // divide by 25 as multiply by reciprocal: floor(x * 5243 / 2^17) == x / 25
  localparam int DIV_MULT  = 5243;
  localparam int DIV_SHIFT = 17;
  localparam int PROD_W    = 2 * TSUM_W;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // input kind carried on tuser
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // register addresses (register index is paddr bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // per-item tags decided by the front
  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } bblur_tag_t;

  // one queue entry: a column of the neighborhood, top row at index 0
  typedef struct packed {
    logic [DIAM-1:0][PIX_W-1:0] col;
    bblur_tag_t                 tag;
  } bblur_item_t;

  // sum of one channel over a column of five pixels
  function automatic logic [CSUM_W-1:0] col_sum(input logic [DIAM-1:0][PIX_W-1:0] col,
                                                input int chan);
    logic [CSUM_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < DIAM; i++) begin
      acc = acc + CSUM_W'(col[i][chan*CHAN_W +: CHAN_W]);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

FILE: design/bblur_ram.sv
// bblur_ram: generic simple dual-port ram, one write and one registered read
// read returns old contents on a same-cycle write to the same address; no dependencies
`default_nettype none

module bblur_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/bblur_front.sv
// bblur_front: accepts input transactions, tracks frame position, decides each
// item's result tags and reads/updates the line store; uses bblur_pkg, bblur_ram
`default_nettype none

module bblur_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_clear,
  input  wire logic [bblur_pkg::WREG_W-1:0]   w_eff,
  input  wire logic [bblur_pkg::HREG_W-1:0]   h_eff,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [bblur_pkg::PIX_W-1:0]    s_tdata,
  input  wire logic                           s_tuser,
  input  wire logic [bblur_pkg::QCNT_W-1:0]   q_count,
  output logic                                push,
  output bblur_pkg::bblur_item_t              push_item
);
  import bblur_pkg::*;

  // frame position
  logic [COL_W-1:0]  in_column;
  logic [HREG_W-1:0] in_row;
  logic [LAG_W-1:0]  pre_count;
  logic [HREG_W-1:0] out_row;
  logic [COL_W-1:0]  out_col;

  // line store read stage
  logic                   r1_valid;
  logic [PIX_W-1:0]       r1_px;
  logic [COL_W-1:0]       r1_col;
  bblur_tag_t             r1_tag;
  logic                   r1_fwd;
  logic [LINE_WORD_W-1:0] r1_fwd_data;

  logic [LINE_WORD_W-1:0] rd_data;
  logic [LINE_WORD_W-1:0] old_word;
  logic [LINE_WORD_W-1:0] wr_data;

  logic              accept;
  logic              complete;
  logic              live;
  logic [WREG_W-1:0] col_inc;
  logic              col_wrap;
  logic [LAG_W-1:0]  lag;
  logic              emit;
  logic [WREG_W-1:0] ocol_inc;
  logic              ocol_wrap;
  logic              last;
  logic              interior;
  logic [PIX_W-1:0]  px;

  // room for the item in flight plus this one
  assign s_tready = (QCNT_W'(q_count) + QCNT_W'(r1_valid)) < QCNT_W'(QUEUE_DEPTH);
  assign accept   = s_tvalid && s_tready;

  // classify: a drain before the frame is complete is dropped
  assign complete = in_row >= h_eff;
  assign live     = accept && !((s_tuser == ACT_DRAIN) && !complete);
  assign px       = complete ? '0 : s_tdata;

  // column / row bookkeeping
  assign col_inc  = {1'b0, in_column} + WREG_W'(1);
  assign col_wrap = col_inc >= w_eff;
  assign lag      = {w_eff, 1'b0} + LAG_W'(RADIUS);
  assign emit     = pre_count == lag;

  // result position tags
  assign ocol_inc  = {1'b0, out_col} + WREG_W'(1);
  assign ocol_wrap = ocol_inc >= w_eff;
  assign last      = (out_row == h_eff - HREG_W'(1)) && ocol_wrap;
  assign interior  = (out_row >= HREG_W'(RADIUS))
                  && (({1'b0, out_row} + (HREG_W+1)'(RADIUS)) < {1'b0, h_eff})
                  && (out_col >= COL_W'(RADIUS))
                  && (({1'b0, out_col} + WREG_W'(RADIUS)) < w_eff);

  // position counters
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      in_column <= '0;
      in_row    <= '0;
      pre_count <= '0;
      out_row   <= '0;
      out_col   <= '0;
    end else if (live) begin
      if (emit && last) begin
        in_column <= '0;
        in_row    <= '0;
        pre_count <= '0;
        out_row   <= '0;
        out_col   <= '0;
      end else begin
        if (col_wrap) begin
          in_column <= '0;
          if (!complete) begin
            in_row <= in_row + HREG_W'(1);
          end
        end else begin
          in_column <= col_inc[COL_W-1:0];
        end
        if (!emit) begin
          pre_count <= pre_count + LAG_W'(1);
        end else if (ocol_wrap) begin
          out_col <= '0;
          out_row <= out_row + HREG_W'(1);
        end else begin
          out_col <= ocol_inc[COL_W-1:0];
        end
      end
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else begin
      r1_valid <= live;
    end
  end

  // read stage payload, with bypass of a same-cycle write to the same column
  always_ff @(posedge clk) begin
    r1_px       <= px;
    r1_col      <= in_column;
    r1_tag      <= '{emit: emit, interior: interior, last: last};
    r1_fwd      <= r1_valid && (r1_col == in_column);
    r1_fwd_data <= wr_data;
  end

  // line store: four lines of one column packed in one word, newest line low
  bblur_ram #(
    .WIDTH(LINE_WORD_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (r1_valid),
    .waddr(r1_col),
    .wdata(wr_data),
    .raddr(in_column),
    .rdata(rd_data)
  );

  assign old_word = r1_fwd ? r1_fwd_data : rd_data;
  assign wr_data  = {old_word[LINE_WORD_W-PIX_W-1:0], r1_px};

  // column vector to the queue, oldest row at index 0
  always_comb begin
    push_item.tag = r1_tag;
    push_item.col[DIAM-1] = r1_px;
    for (int j = 0; j < LINES; j++) begin
      push_item.col[DIAM-2-j] = old_word[j*PIX_W +: PIX_W];
    end
  end
  assign push = r1_valid;

endmodule

`default_nettype wire

FILE: design/bblur_queue.sv
// bblur_queue: short fifo of column items between front and back
// uses bblur_pkg for the item type and depth
`default_nettype none

module bblur_queue (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire bblur_pkg::bblur_item_t       push_item,
  input  wire logic                         pop,
  output logic                              q_valid,
  output bblur_pkg::bblur_item_t            q_item,
  output logic [bblur_pkg::QCNT_W-1:0]      q_count
);
  import bblur_pkg::*;

  bblur_item_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign q_item  = entries[rd_ptr];
  assign q_valid = count != '0;
  assign q_count = count;

endmodule

`default_nettype wire

FILE: design/bblur_back.sv
// bblur_back: sliding 5x5 window as column sums, divide by 25 and output register
// uses bblur_pkg for types, sum widths and the reciprocal constant
`default_nettype none

module bblur_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  input  wire bblur_pkg::bblur_item_t     q_item,
  output logic                            pop,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [bblur_pkg::PIX_W-1:0]     m_tdata,
  output logic                            m_tlast
);
  import bblur_pkg::*;

  // window state: five column sums per channel, plus the center column's pixel
  logic [NCHAN-1:0][DIAM-1:0][CSUM_W-1:0] csum;
  logic [RADIUS:0][PIX_W-1:0]             center_hist;

  logic                               adv;
  logic [NCHAN-1:0][CSUM_W-1:0]       new_csum;
  logic [NCHAN-1:0][TSUM_W-1:0]       total;

  // pipeline stages
  logic                               p1_valid;
  logic                               p1_interior;
  logic                               p1_last;
  logic                               p2_valid;
  logic                               p2_interior;
  logic                               p2_last;
  logic [NCHAN-1:0][TSUM_W-1:0]       p2_total;
  logic [PIX_W-1:0]                   p2_center;
  logic                               p3_valid;
  logic                               p3_interior;
  logic                               p3_last;
  logic [NCHAN-1:0][PROD_W-1:0]       p3_prod;
  logic [PIX_W-1:0]                   p3_center;
  logic [PIX_W-1:0]                   result;

  // whole back end moves when the output register is free
  assign adv = !m_tvalid || m_tready;
  assign pop = adv && q_valid;

  // column sums of the incoming column and window totals
  always_comb begin
    for (int k = 0; k < NCHAN; k++) begin
      new_csum[k] = col_sum(q_item.col, k);
      total[k]    = '0;
      for (int j = 0; j < DIAM; j++) begin
        total[k] = total[k] + TSUM_W'(csum[k][j]);
      end
    end
  end

  // window shift on every item
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int k = 0; k < NCHAN; k++) begin
        for (int j = 0; j < DIAM - 1; j++) begin
          csum[k][j] <= csum[k][j+1];
        end
        csum[k][DIAM-1] <= new_csum[k];
      end
      for (int j = 0; j < RADIUS; j++) begin
        center_hist[j] <= center_hist[j+1];
      end
      center_hist[RADIUS] <= q_item.col[RADIUS];
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      p1_valid <= pop && q_item.tag.emit;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      m_tvalid <= p3_valid;
    end
  end

  // final selection between mean and pass-through
  always_comb begin
    for (int k = 0; k < NCHAN; k++) begin
      result[k*CHAN_W +: CHAN_W] = p3_interior
        ? p3_prod[k][DIV_SHIFT +: CHAN_W]
        : p3_center[k*CHAN_W +: CHAN_W];
    end
  end

  // pipeline payload: total, multiply by reciprocal, output register
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_interior <= q_item.tag.interior;
      p1_last     <= q_item.tag.last;
      p2_interior <= p1_interior;
      p2_last     <= p1_last;
      p2_total    <= total;
      p2_center   <= center_hist[0];
      p3_interior <= p2_interior;
      p3_last     <= p2_last;
      p3_center   <= p2_center;
      for (int k = 0; k < NCHAN; k++) begin
        p3_prod[k] <= PROD_W'(p2_total[k]) * PROD_W'(DIV_MULT);
      end
      m_tdata <= result;
      m_tlast <= p3_last;
    end
  end

endmodule

`default_nettype wire

FILE: design/box_blur_5x5_rgb.sv
// box_blur_5x5_rgb: top level with the register file, front, queue and back
// uses bblur_pkg, bblur_front, bblur_queue, bblur_back
`default_nettype none

// 5x5 box blur over an rgb raster streamed in raster order, one pixel per
// transaction. Each pixel at least two pixels inside every edge becomes the
// per-channel mean of its 5x5 neighborhood (sum / 25, truncated); edge pixels
// pass through. Results trail the input by two rows plus two pixels, so after
// the last pixel of a frame send 2*width+2 drain transactions (tuser = 1) to
// flush it; the final result carries tlast. Drains sent before the frame is
// complete are dropped. The block takes one transaction per clock and gives
// one result per clock while m_tready is high, limited by the single read and
// write port of the 1024 x 96 line store. After the queue a pixel passes p1,
// p2, p3 and the output register. Writing image_width (addr 0) or image_height
// (addr 4) restarts the frame; do it only while the block is idle. A width of
// 0 acts as 1 and widths above 1024 act as 1024; a height of 0 acts as 1.
module box_blur_5x5_rgb (
  input  wire logic        clk,
  input  wire logic        rst,
  // apb register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // pixel_red, pixel_green, pixel_blue
  input  wire logic        s_tuser,   // action
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // out_red, out_green, out_blue
  output logic             m_tlast    // frame_last
);
  import bblur_pkg::*;

  logic [WREG_W-1:0] image_width;
  logic [HREG_W-1:0] image_height;
  logic [WREG_W-1:0] w_eff;
  logic [HREG_W-1:0] h_eff;
  logic              cfg_write;

  logic              push;
  bblur_item_t       push_item;
  logic              pop;
  logic              q_valid;
  bblur_item_t       q_item;
  logic [QCNT_W-1:0] q_count;

  // register write on the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WREG_W'(640);
      image_height <= HREG_W'(480);
    end else if (cfg_write) begin
      case (paddr[2])
        REG_WIDTH:  image_width  <= pwdata[WREG_W-1:0];
        REG_HEIGHT: image_height <= pwdata[HREG_W-1:0];
        default:    image_width  <= image_width;
      endcase
    end
  end

  // register read
  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      default:    prdata = '0;
    endcase
  end

  // effective frame size
  always_comb begin
    if (image_width == '0) begin
      w_eff = WREG_W'(1);
    end else if (image_width > WREG_W'(MAX_WIDTH)) begin
      w_eff = WREG_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height == '0) ? HREG_W'(1) : image_height;
  end

  bblur_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_clear(cfg_write),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_count  (q_count),
    .push     (push),
    .push_item(push_item)
  );

  bblur_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_count  (q_count)
  );

  bblur_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

`default_nettype wire
